### rtl/aabb_xf_pkg.sv
// Shared widths, register indexes and types for the box transform pipeline.
package aabb_xf_pkg;

  localparam int CoordW    = 32;
  localparam int HalfW     = CoordW - 1;
  localparam int ScaleW    = 16;
  localparam int QuatW     = 16;
  localparam int MatW      = 32;
  localparam int AbsW      = MatW - 1;
  localparam int NumRegs   = 8;
  localparam int CfgIdxW   = $clog2(NumRegs);
  localparam int CfgDataW  = CoordW;
  localparam int NumStages = 6;
  localparam int TdataW    = ((3 * CoordW + 3 * HalfW + 7) / 8) * 8;

  localparam logic [CfgIdxW-1:0] RegScale = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRotW  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRotX  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRotY  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRotZ  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMoveX = 3'd5;
  localparam logic [CfgIdxW-1:0] RegMoveY = 3'd6;
  localparam logic [CfgIdxW-1:0] RegMoveZ = 3'd7;

  localparam logic [ScaleW-1:0]       ScaleOne = 16'd256;
  localparam logic signed [QuatW-1:0] QOne     = 16'sd16384;
  localparam logic signed [MatW-1:0]  MatOne   = 32'sd268435456;

  typedef struct packed {
    logic [2:0][MatW-1:0] m;
    logic [2:0][AbsW-1:0] a;
  } mrow_t;

  typedef struct packed {
    logic mul;
    logic sum;
    logic scl;
    logic rnd;
    logic out;
  } pipe_en_t;

endpackage

### rtl/aabb_xf_rot.sv
// Rotation matrix and its absolute value, built from the quaternion registers.
module aabb_xf_rot
  import aabb_xf_pkg::*;
(
  input  logic                   clk_i,
  input  logic [QuatW-1:0]       rot_w_i,
  input  logic [QuatW-1:0]       rot_x_i,
  input  logic [QuatW-1:0]       rot_y_i,
  input  logic [QuatW-1:0]       rot_z_i,
  output mrow_t [2:0]            rows_o
);

  function automatic logic signed [QuatW-1:0] clamp_q(input logic [QuatW-1:0] raw);
    logic signed [QuatW-1:0] v;
    v = $signed(raw);
    if (v > QOne) begin
      return QOne;
    end else if (v < -QOne) begin
      return -QOne;
    end
    return v;
  endfunction

  function automatic logic [AbsW-1:0] mag(input logic signed [MatW-1:0] v);
    logic signed [MatW-1:0] n;
    n = (v < 0) ? -v : v;
    return n[AbsW-1:0];
  endfunction

  logic signed [QuatW-1:0]   qw, qx, qy, qz;
  logic signed [2*QuatW-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic signed [MatW-1:0]    m_d [3][3];
  mrow_t [2:0]               rows_d;
  mrow_t [2:0]               rows_q;

  always_comb begin
    qw = clamp_q(rot_w_i);
    qx = clamp_q(rot_x_i);
    qy = clamp_q(rot_y_i);
    qz = clamp_q(rot_z_i);
    xx = qx * qx;
    yy = qy * qy;
    zz = qz * qz;
    xy = qx * qy;
    xz = qx * qz;
    yz = qy * qz;
    wx = qw * qx;
    wy = qw * qy;
    wz = qw * qz;
    m_d[0][0] = MatOne - ((yy + zz) <<< 1);
    m_d[0][1] = (xy - wz) <<< 1;
    m_d[0][2] = (xz + wy) <<< 1;
    m_d[1][0] = (xy + wz) <<< 1;
    m_d[1][1] = MatOne - ((xx + zz) <<< 1);
    m_d[1][2] = (yz - wx) <<< 1;
    m_d[2][0] = (xz - wy) <<< 1;
    m_d[2][1] = (yz + wx) <<< 1;
    m_d[2][2] = MatOne - ((xx + yy) <<< 1);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rows_d[i].m[j] = m_d[i][j];
        rows_d[i].a[j] = mag(m_d[i][j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rows_q <= rows_d;
  end

  assign rows_o = rows_q;

endmodule

### rtl/aabb_xf_row.sv
// One output axis: row products, row sum, scale, rounding, translate and saturate.
module aabb_xf_row
  import aabb_xf_pkg::*;
(
  input  logic                   clk_i,
  input  pipe_en_t               en_i,
  input  mrow_t                  row_i,
  input  logic [2:0][CoordW-1:0] center_i,
  input  logic [2:0][HalfW-1:0]  half_i,
  input  logic [ScaleW-1:0]      scale_i,
  input  logic [CoordW-1:0]      move_i,
  output logic [CoordW-1:0]      center_o,
  output logic [HalfW-1:0]       half_o
);

  localparam int PcW   = MatW + CoordW;
  localparam int PhW   = AbsW + HalfW;
  localparam int SumW  = PcW;
  localparam int LoW   = SumW / 2;
  localparam int HiW   = SumW - LoW;
  localparam int ClW   = ScaleW + LoW;
  localparam int ChW   = ScaleW + 1 + HiW;
  localparam int EhW   = ScaleW + HiW;
  localparam int CpW   = ChW + LoW;
  localparam int EpW   = EhW + LoW;
  localparam int Shift = 36;
  localparam int RcW   = CpW - Shift;
  localparam int ReW   = EpW - Shift;
  localparam int CsW   = RcW + 1;

  localparam logic signed [CpW-1:0] RoundC = CpW'(1) <<< (Shift - 1);
  localparam logic [EpW-1:0]        RoundE = EpW'(1) << (Shift - 1);
  localparam logic signed [CsW-1:0] CMax   = CsW'((64'd1 << (CoordW - 1)) - 64'd1);
  localparam logic signed [CsW-1:0] CMin   = -CMax - CsW'(1);
  localparam logic [ReW-1:0]        HMax   = ReW'((64'd1 << HalfW) - 64'd1);

  logic signed [PcW-1:0]  pc_q [3];
  logic [PhW-1:0]         ph_q [3];
  logic signed [SumW-1:0] sc_q;
  logic [SumW-1:0]        se_q;
  logic [ClW-1:0]         cl_q;
  logic signed [ChW-1:0]  ch_q;
  logic [ClW-1:0]         el_q;
  logic [EhW-1:0]         eh_q;
  logic signed [CpW-1:0]  cp_d;
  logic [EpW-1:0]         ep_d;
  logic signed [RcW-1:0]  rc_q;
  logic [ReW-1:0]         re_q;
  logic signed [CsW-1:0]  cs_d;
  logic [CoordW-1:0]      center_q;
  logic [HalfW-1:0]       half_q;

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      for (int j = 0; j < 3; j++) begin
        pc_q[j] <= $signed(row_i.m[j]) * $signed(center_i[j]);
        ph_q[j] <= row_i.a[j] * half_i[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      sc_q <= pc_q[0] + pc_q[1] + pc_q[2];
      se_q <= {{(SumW-PhW){1'b0}}, ph_q[0]} + {{(SumW-PhW){1'b0}}, ph_q[1]}
            + {{(SumW-PhW){1'b0}}, ph_q[2]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.scl) begin
      cl_q <= scale_i * sc_q[LoW-1:0];
      ch_q <= $signed({1'b0, scale_i}) * $signed(sc_q[SumW-1:LoW]);
      el_q <= scale_i * se_q[LoW-1:0];
      eh_q <= scale_i * se_q[SumW-1:LoW];
    end
  end

  assign cp_d = $signed({ch_q, {LoW{1'b0}}}) + $signed({{(CpW-ClW){1'b0}}, cl_q}) + RoundC;
  assign ep_d = {eh_q, {LoW{1'b0}}} + {{(EpW-ClW){1'b0}}, el_q} + RoundE;

  always_ff @(posedge clk_i) begin
    if (en_i.rnd) begin
      rc_q <= cp_d[CpW-1:Shift];
      re_q <= ep_d[EpW-1:Shift];
    end
  end

  assign cs_d = {rc_q[RcW-1], rc_q} + {{(CsW-CoordW){move_i[CoordW-1]}}, move_i};

  always_ff @(posedge clk_i) begin
    if (en_i.out) begin
      if (cs_d > CMax) begin
        center_q <= CMax[CoordW-1:0];
      end else if (cs_d < CMin) begin
        center_q <= CMin[CoordW-1:0];
      end else begin
        center_q <= cs_d[CoordW-1:0];
      end
      if (re_q > HMax) begin
        half_q <= HMax[HalfW-1:0];
      end else begin
        half_q <= re_q[HalfW-1:0];
      end
    end
  end

  assign center_o = center_q;
  assign half_o   = half_q;

endmodule

### rtl/aabb_rigid_transform.sv
// Requests pass input, mul, sum, scl, rnd and out registers to the master.
// Throughput: one box per cycle; every stage holds under backpressure and
// fills bubbles.
// A config write takes effect for requests accepted on the following cycle.
// Reset clears all stage valids and loads the identity transform (scale 1.0,
// unit quaternion, zero translation).
module aabb_rigid_transform
  import aabb_xf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // center_x, center_y, center_z, half_x, half_y, half_z, zero pad
  input  logic [TdataW-1:0]   s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // center_x, center_y, center_z, half_x, half_y, half_z, zero pad
  output logic [TdataW-1:0]   m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [ScaleW-1:0]      scale_q;
  logic [QuatW-1:0]       rot_w_q, rot_x_q, rot_y_q, rot_z_q;
  logic [2:0][CoordW-1:0] move_q;

  mrow_t [2:0]            rows;
  logic [NumStages-1:0]   v_q;
  logic [NumStages:0]     rdy;
  pipe_en_t               en;

  logic [2:0][CoordW-1:0] center_q;
  logic [2:0][HalfW-1:0]  half_q;
  logic [2:0][CoordW-1:0] out_center;
  logic [2:0][HalfW-1:0]  out_half;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleOne;
      rot_w_q <= QOne;
      rot_x_q <= '0;
      rot_y_q <= '0;
      rot_z_q <= '0;
      move_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegScale: scale_q   <= cfg_data_i[ScaleW-1:0];
        RegRotW:  rot_w_q   <= cfg_data_i[QuatW-1:0];
        RegRotX:  rot_x_q   <= cfg_data_i[QuatW-1:0];
        RegRotY:  rot_y_q   <= cfg_data_i[QuatW-1:0];
        RegRotZ:  rot_z_q   <= cfg_data_i[QuatW-1:0];
        RegMoveX: move_q[0] <= cfg_data_i[CoordW-1:0];
        RegMoveY: move_q[1] <= cfg_data_i[CoordW-1:0];
        RegMoveZ: move_q[2] <= cfg_data_i[CoordW-1:0];
        default: ;
      endcase
    end
  end

  aabb_xf_rot u_rot (
    .clk_i   (clk_i),
    .rot_w_i (rot_w_q),
    .rot_x_i (rot_x_q),
    .rot_y_i (rot_y_q),
    .rot_z_i (rot_z_q),
    .rows_o  (rows)
  );

  // a stage advances when it is empty or the stage after it advances
  always_comb begin
    rdy[NumStages] = m_axis_tready;
    for (int k = NumStages - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign en.mul = rdy[1];
  assign en.sum = rdy[2];
  assign en.scl = rdy[3];
  assign en.rnd = rdy[4];
  assign en.out = rdy[5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && s_axis_tvalid) begin
      for (int i = 0; i < 3; i++) begin
        center_q[i] <= s_axis_tdata[i*CoordW +: CoordW];
        half_q[i]   <= s_axis_tdata[3*CoordW + i*HalfW +: HalfW];
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_axis
    aabb_xf_row u_row (
      .clk_i    (clk_i),
      .en_i     (en),
      .row_i    (rows[g]),
      .center_i (center_q),
      .half_i   (half_q),
      .scale_i  (scale_q),
      .move_i   (move_q[g]),
      .center_o (out_center[g]),
      .half_o   (out_half[g])
    );
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = v_q[NumStages-1];
  assign m_axis_tdata  = {{(TdataW - 3*CoordW - 3*HalfW){1'b0}},
                          out_half[2], out_half[1], out_half[0],
                          out_center[2], out_center[1], out_center[0]};

`ifndef SYNTHESIS
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (&v_q && !m_axis_tready))
    else $error("input stalled while the pipeline has a free stage");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v_q[0])
    else $error("accepted request did not enter the first stage");

  a_shift_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NumStages-2] && m_axis_tready) |=> m_axis_tvalid)
    else $error("result lost between rounding and output stage");

  a_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rot_w_q == QOne && rot_x_q == '0 && rot_y_q == '0 && rot_z_q == '0)
    |=> (rows[0].m[0] == MatOne && rows[1].m[1] == MatOne && rows[2].m[2] == MatOne
         && rows[0].m[1] == '0 && rows[1].m[2] == '0 && rows[2].m[0] == '0))
    else $error("identity quaternion did not give an identity matrix");
`endif

endmodule

### test/aabb_rigid_transform_tb.sv
// Testbench for aabb_rigid_transform: directed and random boxes checked against a scale/rotate/translate predictor.
module aabb_rigid_transform_tb;
  import aabb_xf_pkg::*;

  localparam int StuckLimit = 5000;
  localparam int HoldLen    = 300;
  localparam int PlanRows   = 21;
  localparam int SetsPerRun = 4;
  localparam int BoxesPerSet = 100;

  typedef struct packed {
    logic [ScaleW-1:0] scale;
    logic [QuatW-1:0]  rot_w;
    logic [QuatW-1:0]  rot_x;
    logic [QuatW-1:0]  rot_y;
    logic [QuatW-1:0]  rot_z;
    logic [CoordW-1:0] move_x;
    logic [CoordW-1:0] move_y;
    logic [CoordW-1:0] move_z;
  } xf_cfg_t;

  typedef struct packed {
    logic [CoordW-1:0] center_x;
    logic [CoordW-1:0] center_y;
    logic [CoordW-1:0] center_z;
    logic [HalfW-1:0]  half_x;
    logic [HalfW-1:0]  half_y;
    logic [HalfW-1:0]  half_z;
  } box_t;

  typedef enum logic [1:0] {RowBox, RowBoxChecked, RowConfig} row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    xf_cfg_t   cfg;
    box_t      box;
    box_t      want;
  } plan_row_t;

  localparam plan_row_t Plan [PlanRows] = '{
    '{RowBoxChecked, '0, '0, '0},
    '{RowBoxChecked, '0,
      '{32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 31'h7fff_ffff, 31'h0, 31'h0001_8000},
      '{32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 31'h7fff_ffff, 31'h0, 31'h0001_8000}},
    '{RowBoxChecked, '0,
      '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000, 31'h0, 31'h7fff_ffff, 31'h1},
      '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000, 31'h0, 31'h7fff_ffff, 31'h1}},
    '{RowBox, '0,
      '{32'h1234_5678, 32'hedcb_a987, 32'h0000_0001, 31'h00ab_cdef, 31'h0123_4567, 31'h0}, '0},
    '{RowConfig,
      '{16'hffff, 16'h4000, 16'h0, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0}, '0, '0},
    '{RowBoxChecked, '0,
      '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 31'h7fff_ffff, 31'h0, 31'h0},
      '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 31'h7fff_ffff, 31'h0, 31'h0}},
    '{RowBox, '0,
      '{32'h0001_0000, 32'hfffe_0000, 32'h0000_0100, 31'h0000_8000, 31'h1, 31'h0001_0000}, '0},
    '{RowConfig,
      '{16'h0, 16'h4000, 16'h0, 16'h0, 16'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h0}, '0, '0},
    '{RowBoxChecked, '0,
      '{32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678, 31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff},
      '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 31'h0, 31'h0, 31'h0}},
    '{RowConfig,
      '{16'h0100, 16'h0, 16'h0, 16'h0, 16'h4000, 32'h0, 32'h0, 32'h0}, '0, '0},
    '{RowBoxChecked, '0,
      '{32'h8000_0000, 32'h0005_0000, 32'h0000_0007, 31'h1, 31'h2, 31'h3},
      '{32'h7fff_ffff, 32'hfffb_0000, 32'h0000_0007, 31'h1, 31'h2, 31'h3}},
    '{RowBox, '0,
      '{32'h0012_3456, 32'hff87_6543, 32'h7fff_ffff, 31'h0040_0000, 31'h10, 31'h7fff_ffff}, '0},
    '{RowConfig,
      '{16'h0180, 16'h8000, 16'h7fff, 16'hc001, 16'h4001,
        32'h0001_0000, 32'hffff_0000, 32'h4000_0000}, '0, '0},
    '{RowBox, '0,
      '{32'h0003_8000, 32'hfff0_0001, 32'h0100_0000, 31'h0002_0000, 31'h0000_4000, 31'h1}, '0},
    '{RowBox, '0,
      '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff, 31'h0, 31'h7fff_ffff}, '0},
    '{RowConfig,
      '{16'h0080, 16'd15137, 16'd6270, 16'h0, 16'h0,
        32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff}, '0, '0},
    '{RowBox, '0,
      '{32'h0000_ffff, 32'h0007_0000, 32'hfff9_0000, 31'h0001_0000, 31'h0003_0000, 31'h5}, '0},
    '{RowBox, '0,
      '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 31'h5555_5555, 31'h2aaa_aaaa, 31'h0}, '0},
    '{RowConfig,
      '{16'hffff, 16'hc000, 16'hc000, 16'hc000, 16'hc000,
        32'h0000_0001, 32'h0, 32'hffff_fffe}, '0, '0},
    '{RowBox, '0,
      '{32'h0000_0100, 32'hffff_ff00, 32'h0001_0000, 31'h0000_0100, 31'h0000_0200, 31'h1}, '0},
    '{RowBox, '0,
      '{32'h7fff_ffff, 32'h0, 32'h8000_0001, 31'h0, 31'h7fff_ffff, 31'h0001_0000}, '0}
  };

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [TdataW-1:0] s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [TdataW-1:0] m_axis_tdata;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  xf_cfg_t live_cfg = '{ScaleOne, QOne, 16'h0, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0};
  box_t    expected_boxes [$];
  int      mismatches   = 0;
  int      stuck_cycles = 0;
  int      tx_idle_pct  = 0;
  int      rx_idle_pct  = 0;
  int      hold_asked   = 0;
  int      hold_done    = 0;
  int      hold_left    = 0;
  string   field_name [6] = '{"center_x", "center_y", "center_z", "half_x", "half_y", "half_z"};

  aabb_rigid_transform dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [TdataW-1:0] box_bits(box_t b);
    return TdataW'({b.half_z, b.half_y, b.half_x, b.center_z, b.center_y, b.center_x});
  endfunction

  function automatic longint clamp_quat(logic [QuatW-1:0] raw);
    longint v;
    v = longint'($signed(raw));
    if (v > longint'(QOne)) v = longint'(QOne);
    if (v < -longint'(QOne)) v = -longint'(QOne);
    return v;
  endfunction

  function automatic logic signed [95:0] clip96(logic signed [95:0] v, logic signed [95:0] lo,
                                                logic signed [95:0] hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic box_t transform_box(box_t b, xf_cfg_t c);
    longint w, x, y, z, one;
    longint rot [3][3];
    longint cen [3];
    longint hlf [3];
    longint mv [3];
    logic signed [95:0] cacc, hacc, lo_c, hi_c;
    box_t r;
    w = clamp_quat(c.rot_w);
    x = clamp_quat(c.rot_x);
    y = clamp_quat(c.rot_y);
    z = clamp_quat(c.rot_z);
    one = longint'(MatOne);
    rot[0][0] = one - 2 * (y * y + z * z);
    rot[0][1] = 2 * (x * y - w * z);
    rot[0][2] = 2 * (x * z + w * y);
    rot[1][0] = 2 * (x * y + w * z);
    rot[1][1] = one - 2 * (x * x + z * z);
    rot[1][2] = 2 * (y * z - w * x);
    rot[2][0] = 2 * (x * z - w * y);
    rot[2][1] = 2 * (y * z + w * x);
    rot[2][2] = one - 2 * (x * x + y * y);
    cen[0] = longint'(c.scale) * longint'($signed(b.center_x));
    cen[1] = longint'(c.scale) * longint'($signed(b.center_y));
    cen[2] = longint'(c.scale) * longint'($signed(b.center_z));
    hlf[0] = longint'(c.scale) * longint'(b.half_x);
    hlf[1] = longint'(c.scale) * longint'(b.half_y);
    hlf[2] = longint'(c.scale) * longint'(b.half_z);
    mv[0] = longint'($signed(c.move_x));
    mv[1] = longint'($signed(c.move_y));
    mv[2] = longint'($signed(c.move_z));
    hi_c = (96'sd1 <<< (CoordW - 1)) - 96'sd1;
    lo_c = -(96'sd1 <<< (CoordW - 1));
    r = '0;
    for (int i = 0; i < 3; i++) begin
      cacc = '0;
      hacc = '0;
      for (int j = 0; j < 3; j++) begin
        cacc = cacc + 96'(rot[i][j]) * 96'(cen[j]);
        hacc = hacc + 96'(rot[i][j] < 0 ? -rot[i][j] : rot[i][j]) * 96'(hlf[j]);
      end
      cacc = ((cacc + (96'sd1 <<< 35)) >>> 36) + 96'(mv[i]);
      hacc = (hacc + (96'sd1 <<< 35)) >>> 36;
      cacc = clip96(cacc, lo_c, hi_c);
      hacc = clip96(hacc, 96'sd0, hi_c);
      case (i)
        0: begin
          r.center_x = cacc[CoordW-1:0];
          r.half_x   = hacc[HalfW-1:0];
        end
        1: begin
          r.center_y = cacc[CoordW-1:0];
          r.half_y   = hacc[HalfW-1:0];
        end
        default: begin
          r.center_z = cacc[CoordW-1:0];
          r.half_z   = hacc[HalfW-1:0];
        end
      endcase
    end
    return r;
  endfunction

  function automatic logic [31:0] rand_coord(bit nonneg);
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        v = $urandom_range(0, 32'h0020_0000);
        if (!nonneg && $urandom_range(0, 1) == 1) v = -v;
      end
      6, 7, 8: v = $urandom;
      default: v = (nonneg || $urandom_range(0, 1) == 1) ? 32'h7fff_ffff : 32'h8000_0000;
    endcase
    return v;
  endfunction

  function automatic logic [QuatW-1:0] rand_quat_part();
    logic [QuatW-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        case ($urandom_range(0, 4))
          0: v = '0;
          1: v = 16'sd11585;
          2: v = -16'sd11585;
          3: v = QOne;
          default: v = -QOne;
        endcase
      end
      3, 4, 5, 6, 7: v = 16'($urandom_range(0, 32768) - 16384);
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic push_box(box_t b, bit typed, box_t want);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= box_bits(b);
    do @(posedge clk_i); while (!s_axis_tready);
    expected_boxes.push_back(typed ? want : transform_box(b, live_cfg));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_boxes.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_xform(xf_cfg_t c);
    logic [CfgDataW-1:0] value [NumRegs];
    value[RegScale] = {16'($urandom), c.scale};
    value[RegRotW]  = {16'($urandom), c.rot_w};
    value[RegRotX]  = {16'($urandom), c.rot_x};
    value[RegRotY]  = {16'($urandom), c.rot_y};
    value[RegRotZ]  = {16'($urandom), c.rot_z};
    value[RegMoveX] = c.move_x;
    value[RegMoveY] = c.move_y;
    value[RegMoveZ] = c.move_z;
    for (int i = 0; i < NumRegs; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CfgIdxW'(i);
      cfg_data_i <= value[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    live_cfg = c;
  endtask

  always @(posedge clk_i) begin
    if (hold_done != hold_asked) begin
      hold_done     <= hold_done + 1;
      hold_left     <= HoldLen;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    box_t              want;
    logic [TdataW-1:0] want_bits;
    logic [31:0]       wf, gf;
    int                off;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_boxes.size() == 0) begin
        $error("result with no request pending: %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_boxes.pop_front();
        want_bits = box_bits(want);
        for (int i = 0; i < 6; i++) begin
          off = i < 3 ? i * CoordW : 3 * CoordW + (i - 3) * HalfW;
          wf = 32'(want_bits >> off);
          gf = 32'(m_axis_tdata >> off);
          if (i >= 3) begin
            wf[CoordW-1] = 1'b0;
            gf[CoordW-1] = 1'b0;
          end
          if (wf != gf) begin
            $error("%s: expected %h, got %h", field_name[i], wf, gf);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || cfg_we_i) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("[aabb_rigid_transform] ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    xf_cfg_t next_cfg;
    box_t    b;
    tx_idle_pct = 28;
    rx_idle_pct <= 81;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < PlanRows; i++) begin
      case (Plan[i].kind)
        RowConfig: begin
          drain();
          load_xform(Plan[i].cfg);
        end
        RowBoxChecked: push_box(Plan[i].box, 1'b1, Plan[i].want);
        default:       push_box(Plan[i].box, 1'b0, '0);
      endcase
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 28;
          rx_idle_pct <= 81;
        end
        1: begin
          tx_idle_pct = 81;
          rx_idle_pct <= 28;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
        end
      endcase
      for (int k = 0; k < SetsPerRun; k++) begin
        drain();
        case ($urandom_range(0, 4))
          0: next_cfg.scale = ScaleOne;
          1: next_cfg.scale = '1;
          2: next_cfg.scale = '0;
          3: next_cfg.scale = 16'($urandom_range(64, 1024));
          default: next_cfg.scale = 16'($urandom);
        endcase
        next_cfg.rot_w  = rand_quat_part();
        next_cfg.rot_x  = rand_quat_part();
        next_cfg.rot_y  = rand_quat_part();
        next_cfg.rot_z  = rand_quat_part();
        next_cfg.move_x = rand_coord(1'b0);
        next_cfg.move_y = rand_coord(1'b0);
        next_cfg.move_z = rand_coord(1'b0);
        load_xform(next_cfg);
        if (ph == 2 && k == 0) hold_asked <= hold_asked + 1;
        for (int n = 0; n < BoxesPerSet; n++) begin
          b.center_x = rand_coord(1'b0);
          b.center_y = rand_coord(1'b0);
          b.center_z = rand_coord(1'b0);
          b.half_x   = 31'(rand_coord(1'b1));
          b.half_y   = 31'(rand_coord(1'b1));
          b.half_z   = 31'(rand_coord(1'b1));
          push_box(b, 1'b0, '0);
        end
      end
    end

    drain();
    repeat (NumStages + 4) @(posedge clk_i);
    if (mismatches == 0 && expected_boxes.size() == 0) begin
      $display("[aabb_rigid_transform] OK");
    end else begin
      $display("[aabb_rigid_transform] ERROR");
    end
    $finish;
  end

endmodule
